// ===== rtl/mtf_pkg.sv =====
`default_nettype none
package mtf_pkg;
    localparam int ALPHABET_DEF = 256;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_BUCKET = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_MAP   = 3'd0,
        PH_LIST  = 3'd1,
        PH_RANK2 = 3'd2,
        PH_RANK3 = 3'd3,
        PH_RANK10 = 3'd4,
        PH_RUN   = 3'd5,
        PH_ESC   = 3'd6
    } phase_t;

    // command from the controller to the list chain
    typedef struct packed {
        logic       load;      // write load_pos with data
        logic [7:0] load_pos;
        logic       shift;     // move entries 1..top down by one, front gets data
        logic [7:0] top;
        logic [7:0] data;
    } chain_cmd_t;

    function automatic logic [3:0] bitlen9(input logic [8:0] u);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++)
            if (u[i]) n = 4'(i + 1);
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mtf_if.sv =====
`default_nettype none
interface mtf_in_if;
    logic valid;
    logic ready;
    logic bit_in;
    modport source (output valid, output bit_in, input ready);
    modport sink (input valid, input bit_in, output ready);
endinterface

interface mtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [8:0] run_count;
    logic       last;
    modport source (output valid, output symbol, output run_count, output last, input ready);
    modport sink (input valid, input symbol, input run_count, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mtf_cell.sv =====
`default_nettype none
module mtf_cell #(
    parameter int POS = 0
) (
    input  wire logic            clk,
    input  wire mtf_pkg::chain_cmd_t cmd,
    input  wire logic [7:0]      prev,
    output logic [7:0]           value
);
    import mtf_pkg::*;
    logic [7:0] value_reg, value_next;
    always_comb
    begin
        value_next = value_reg;
        if (cmd.load && cmd.load_pos == 8'(POS))
            value_next = cmd.data;
        else if (cmd.shift && 8'(POS) <= cmd.top)
            value_next = (POS == 0) ? cmd.data : prev;
    end
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end
    assign value = value_reg;
endmodule
`default_nettype wire

// ===== rtl/mtf_chain.sv =====
`default_nettype none
module mtf_chain #(
    parameter int DEPTH = mtf_pkg::ALPHABET_DEF
) (
    input  wire logic                clk,
    input  wire mtf_pkg::chain_cmd_t cmd,
    output logic [DEPTH-1:0][7:0]    entries
);
    import mtf_pkg::*;
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            mtf_cell #(.POS(g)) u_cell (
                .clk(clk), .cmd(cmd),
                .prev(g == 0 ? 8'd0 : entries[(g == 0) ? 0 : g-1]),
                .value(entries[g])
            );
        end
    endgenerate
endmodule
`default_nettype wire

// ===== rtl/mtf_bucket_decoder_unit.sv =====
`default_nettype none
// Move-to-front bucket decoder.
// in_ch carries one compressed bit per item, MSB first per field. out_ch
// carries (symbol, run_count, last) per decoded run. cfg_we/cfg_idx/cfg_data
// write map length (0), bucket_len (1), mtf_limit (2); write only when idle.
// A bit that completes a run code produces the result in the output
// register on the next edge.
// The list lives in a row of cells; a move-to-front or escape push shifts the
// entries up to the moved rank or list end in the same cycle, with no stall.
// The symbol map is a register array written one entry per set map bit; the
// remap read is registered and lands together with the output register.
// Throughput: one bit per cycle while the output register is free. When the
// receiver stalls, the result is held and in_ch.ready stays low until the
// held result is taken.
// Reset: control and config registers return to their defaults and the decoder
// waits for the local map of a new bucket. level3 width persists across buckets.
module mtf_bucket_decoder_unit #(
    parameter int ALPHABET = mtf_pkg::ALPHABET_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    mtf_in_if.sink                              in_ch,
    mtf_out_if.source                           out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [mtf_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [mtf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtf_pkg::*;

    logic [8:0]  alpha_reg, limit_reg;
    logic [16:0] blen_reg;
    phase_t      phase_reg, phase_next;
    logic [8:0]  left_reg, left_next, accum_reg, accum_next, map_idx_reg, map_idx_next;
    logic [8:0]  lcount_reg, lcount_next, lsize_reg, lsize_next, rank_reg, rank_next;
    logic [3:0]  sbits_reg, sbits_next, l3_reg, l3_next;
    logic [16:0] prod_reg, prod_next;
    logic [7:0]  map_mem [ALPHABET];
    logic [7:0]  map_rdata_reg;
    logic        map_re;
    logic [7:0]  map_raddr;
    logic        ov_reg, ov_next, olast_reg, olast_next;
    logic        osym_ok_reg, osym_ok_next;
    logic [8:0]  orun_reg, orun_next;
    chain_cmd_t  cmd;
    logic [ALPHABET-1:0][7:0] ents;
    logic        map_we;
    logic        fire;

    mtf_chain #(.DEPTH(ALPHABET)) u_chain (.clk(clk), .cmd(cmd), .entries(ents));

    assign in_ch.ready = !ov_reg || out_ch.ready;
    assign fire = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ov_reg;
    assign out_ch.symbol = osym_ok_reg ? map_rdata_reg : 8'd0;
    assign out_ch.run_count = orun_reg;
    assign out_ch.last = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 9'd256;
            blen_reg <= 17'd1024;
            limit_reg <= 9'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ALPHA:  alpha_reg <= cfg_data[8:0];
                CFG_BUCKET: blen_reg <= cfg_data;
                CFG_LIMIT:  limit_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    function automatic logic [8:0] eff_alpha(input logic [8:0] a);
        if (a == 9'd0) return 9'd1;
        if (a > 9'(ALPHABET)) return 9'(ALPHABET);
        return a;
    endfunction

    always_comb
    begin
        logic [8:0]  fa, lv, ls, locv, rn;
        logic [16:0] len, lft, run17;
        logic        emit_now, start_rk, newb, resolve_now;
        logic [7:0]  emit_loc;
        logic [8:0]  emit_n;
        phase_next = phase_reg; left_next = left_reg; accum_next = accum_reg;
        map_idx_next = map_idx_reg; lcount_next = lcount_reg; lsize_next = lsize_reg;
        rank_next = rank_reg; sbits_next = sbits_reg; l3_next = l3_reg;
        prod_next = prod_reg;
        ov_next = ov_reg && !out_ch.ready;
        osym_ok_next = osym_ok_reg; orun_next = orun_reg; olast_next = olast_reg;
        cmd = '0; map_we = 1'b0; map_re = 1'b0; map_raddr = 8'd0;
        emit_now = 1'b0; start_rk = 1'b0; resolve_now = 1'b0; newb = 1'b0;
        emit_loc = 8'd0; emit_n = 9'd1; locv = 9'd0; ls = 9'd0;
        len = 17'd0; lft = 17'd0; run17 = 17'd0; rn = rank_reg;
        fa = {accum_reg[7:0], in_ch.bit_in};
        lv = left_reg;
        if (fire)
        begin
            if (phase_reg == PH_MAP)
            begin
                if (in_ch.bit_in && lcount_reg < 9'(ALPHABET))
                begin
                    map_we = 1'b1;
                    lcount_next = lcount_reg + 9'd1;
                end
                map_idx_next = map_idx_reg + 9'd1;
                if (lv != 9'd0) lv = lv - 9'd1;
                left_next = lv;
                if (lv == 9'd0 || map_idx_next >= 9'(ALPHABET))
                begin
                    ls = (limit_reg < lcount_next) ? limit_reg : lcount_next;
                    lsize_next = ls;
                    sbits_next = bitlen9(lcount_next);
                    if (ls > 9'd10) l3_next = bitlen9(ls - 9'd10);
                    rank_next = 9'd0; accum_next = 9'd0;
                    if (ls != 9'd0)
                    begin
                        phase_next = PH_LIST;
                        left_next = 9'(bitlen9(lcount_next));
                    end
                    else start_rk = 1'b1;
                end
            end
            else
            begin
                accum_next = fa;
                if (phase_reg == PH_RANK2)
                begin
                    rn = {rank_reg[7:0], in_ch.bit_in};
                    rank_next = rn;
                end
                if (lv != 9'd0) lv = lv - 9'd1;
                left_next = lv;
                if (lv == 9'd0)
                begin
                    case (phase_reg)
                        PH_LIST:
                        begin
                            cmd.load = 1'b1;
                            cmd.load_pos = rank_reg[7:0];
                            cmd.data = (fa < lcount_reg) ? fa[7:0] : 8'd0;
                            rank_next = rank_reg + 9'd1;
                            accum_next = 9'd0;
                            if (rank_next >= lsize_reg) start_rk = 1'b1;
                            else left_next = 9'(sbits_reg);
                        end
                        PH_RANK2:
                        begin
                            if (rn == 9'd3)
                            begin
                                phase_next = PH_RANK3; left_next = 9'd3; accum_next = 9'd0;
                            end
                            else resolve_now = 1'b1;
                        end
                        PH_RANK3:
                        begin
                            rn = 9'd3 + fa;
                            rank_next = rn;
                            if (rn == 9'd10 && l3_reg != 4'd0)
                            begin
                                phase_next = PH_RANK10; left_next = 9'(l3_reg);
                                accum_next = 9'd0;
                            end
                            else resolve_now = 1'b1;
                        end
                        PH_RANK10:
                        begin
                            rn = 9'd10 + fa;
                            rank_next = rn;
                            resolve_now = 1'b1;
                        end
                        PH_RUN:
                        begin
                            emit_now = 1'b1;
                            emit_loc = (lsize_reg != 9'd0) ? ents[0] : 8'd0;
                            emit_n = 9'(fa[7:0]) + 9'd1;
                        end
                        PH_ESC:
                        begin
                            locv = (fa < lcount_reg) ? fa : 9'd0;
                            cmd.shift = 1'b1;
                            cmd.top = (lsize_reg != 9'd0) ? 8'(lsize_reg - 9'd1) : 8'd0;
                            cmd.data = locv[7:0];
                            emit_now = 1'b1; emit_loc = locv[7:0];
                        end
                        default: start_rk = 1'b1;
                    endcase
                end
            end
            if (resolve_now)
            begin
                if (rn == 9'd0)
                begin
                    phase_next = PH_RUN; left_next = 9'd8; accum_next = 9'd0;
                end
                else if (rn < lsize_reg)
                begin
                    cmd.shift = 1'b1; cmd.top = rn[7:0]; cmd.data = ents[rn[7:0]];
                    emit_now = 1'b1; emit_loc = ents[rn[7:0]];
                end
                else if (sbits_reg == 4'd0)
                begin
                    cmd.shift = 1'b1;
                    cmd.top = (lsize_reg != 9'd0) ? 8'(lsize_reg - 9'd1) : 8'd0;
                    cmd.data = 8'd0;
                    emit_now = 1'b1; emit_loc = 8'd0;
                end
                else
                begin
                    phase_next = PH_ESC; left_next = 9'(sbits_reg); accum_next = 9'd0;
                end
            end
            if (emit_now)
            begin
                len = (blen_reg == 17'd0) ? 17'd1 : blen_reg;
                lft = (len > prod_reg) ? len - prod_reg : 17'd1;
                run17 = (17'(emit_n) < lft) ? 17'(emit_n) : lft;
                prod_next = prod_reg + run17;
                ov_next = 1'b1;
                // remap read lands in map_rdata_reg with the output register
                map_re = 1'b1;
                map_raddr = emit_loc;
                osym_ok_next = 9'(emit_loc) < lcount_reg;
                orun_next = run17[8:0];
                olast_next = prod_next >= len;
                if (prod_next >= len) newb = 1'b1;
                else start_rk = 1'b1;
            end
            if (start_rk)
            begin
                phase_next = PH_RANK2; left_next = 9'd2; rank_next = 9'd0; accum_next = 9'd0;
            end
            if (newb)
            begin
                phase_next = PH_MAP; left_next = eff_alpha(alpha_reg);
                accum_next = 9'd0; map_idx_next = 9'd0; lcount_next = 9'd0;
                lsize_next = 9'd0; sbits_next = 4'd0; rank_next = 9'd0; prod_next = 17'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[lcount_reg[7:0]] <= map_idx_reg[7:0];
        if (map_re)
            map_rdata_reg <= map_mem[map_raddr];
        osym_ok_reg <= osym_ok_next;
        orun_reg <= orun_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAP;
            left_reg <= 9'(ALPHABET);
            accum_reg <= '0; map_idx_reg <= '0; lcount_reg <= '0; lsize_reg <= '0;
            rank_reg <= '0; sbits_reg <= '0; l3_reg <= '0; prod_reg <= '0;
            ov_reg <= 1'b0; olast_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; left_reg <= left_next; accum_reg <= accum_next;
            map_idx_reg <= map_idx_next; lcount_reg <= lcount_next;
            lsize_reg <= lsize_next; rank_reg <= rank_next; sbits_reg <= sbits_next;
            l3_reg <= l3_next; prod_reg <= prod_next;
            ov_reg <= ov_next; olast_reg <= olast_next;
        end
    end

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lsize_reg <= lcount_reg) else $error("list larger than map");
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.run_count != 9'd0) else $error("zero run");
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !$past(out_ch.valid) && out_ch.last) |-> prod_reg == 17'd0)
        else $error("bucket not restarted");
endmodule
`default_nettype wire

// ===== test/mtf_bucket_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
module mtf_bucket_decoder_unit_tb;
    import mtf_pkg::*;

    typedef struct packed {
        logic [7:0] symbol;
        logic [8:0] run_count;
        logic       last;
    } run_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mtf_in_if in_ch();
    mtf_out_if out_ch();

    mtf_bucket_decoder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // decoder model state
    int alpha_reg, blen_reg, limit_reg;
    phase_t ph;
    int bits_left, acc, map_idx, lcnt, lsize, sbits, rank, produced, lvl3;
    logic [7:0] l2g [256];
    logic [7:0] lst [256];

    run_t pending_runs[$];
    int errors;
    int snd_idle, rcv_idle;
    int sent;

    function automatic int width_of(input int u);
        int n;
        n = 0;
        while (u != 0) begin
            n++;
            u = u >> 1;
        end
        return n;
    endfunction

    function automatic int fix_local(input int v);
        return (v < lcnt && v < 256) ? v : 0;
    endfunction

    task automatic start_rank();
        ph = PH_RANK2;
        bits_left = 2;
        rank = 0;
        acc = 0;
    endtask

    task automatic new_bucket();
        ph = PH_MAP;
        bits_left = (alpha_reg == 0) ? 1 : (alpha_reg > 256 ? 256 : alpha_reg);
        acc = 0;
        map_idx = 0;
        lcnt = 0;
        lsize = 0;
        sbits = 0;
        rank = 0;
        produced = 0;
    endtask

    task automatic emit_run(input int loc, input int n, output bit got, output run_t r);
        int len, left, run;
        len = (blen_reg == 0) ? 1 : blen_reg;
        left = (len > produced) ? len - produced : 1;
        run = (n < left) ? n : left;
        produced += run;
        r.symbol = (loc < lcnt && loc < 256) ? l2g[loc] : 8'd0;
        r.run_count = run[8:0];
        r.last = (produced >= len);
        got = 1;
        if (r.last)
            new_bucket();
        else
            start_rank();
    endtask

    task automatic push_escape(input int v, output bit got, output run_t r);
        for (int i = (lsize > 0 ? lsize - 1 : 0); i > 0; i--)
            lst[i & 255] = lst[(i - 1) & 255];
        lst[0] = v[7:0];
        emit_run(v, 1, got, r);
    endtask

    task automatic resolve_rank(output bit got, output run_t r);
        logic [7:0] s;
        got = 0;
        r = '0;
        if (rank == 0) begin
            ph = PH_RUN;
            bits_left = 8;
            acc = 0;
        end
        else if (rank < lsize) begin
            s = lst[rank & 255];
            for (int i = rank & 255; i > 0; i--)
                lst[i] = lst[i - 1];
            lst[0] = s;
            emit_run(s, 1, got, r);
        end
        else if (sbits == 0)
            push_escape(0, got, r);
        else begin
            ph = PH_ESC;
            bits_left = sbits;
            acc = 0;
        end
    endtask

    task automatic decode_bit(input logic b, output bit got, output run_t r);
        got = 0;
        r = '0;
        if (ph == PH_MAP) begin
            if (b && lcnt < 256 && map_idx < 256) begin
                l2g[lcnt] = map_idx[7:0];
                lcnt++;
            end
            map_idx++;
            if (bits_left > 0)
                bits_left--;
            if (bits_left == 0 || map_idx >= 256) begin
                lsize = (limit_reg < lcnt) ? limit_reg : lcnt;
                if (lsize > 256)
                    lsize = 256;
                sbits = width_of(lcnt);
                if (lsize > 10)
                    lvl3 = width_of(lsize - 10);
                if (lsize > 0) begin
                    ph = PH_LIST;
                    bits_left = sbits;
                    rank = 0;
                    acc = 0;
                end
                else
                    start_rank();
            end
            return;
        end
        acc = ((acc << 1) | b) & 'h1FF;
        if (ph == PH_RANK2)
            rank = ((rank << 1) | b) & 'h1FF;
        if (bits_left > 0)
            bits_left--;
        if (bits_left != 0)
            return;
        case (ph)
            PH_LIST:
            begin
                lst[rank & 255] = 8'(fix_local(acc));
                rank++;
                acc = 0;
                if (rank >= lsize)
                    start_rank();
                else
                    bits_left = sbits;
            end
            PH_RANK2:
            begin
                if (rank == 3) begin
                    ph = PH_RANK3;
                    bits_left = 3;
                    acc = 0;
                end
                else
                    resolve_rank(got, r);
            end
            PH_RANK3:
            begin
                rank = 3 + acc;
                if (rank == 10 && lvl3 != 0) begin
                    ph = PH_RANK10;
                    bits_left = lvl3;
                    acc = 0;
                end
                else
                    resolve_rank(got, r);
            end
            PH_RANK10:
            begin
                rank = (10 + acc) & 'h1FF;
                resolve_rank(got, r);
            end
            PH_RUN:
                emit_run((lsize > 0) ? lst[0] : 0, (acc & 'hFF) + 1, got, r);
            PH_ESC:
                push_escape(fix_local(acc), got, r);
            default:
                start_rank();
        endcase
    endtask

    // drive one bit, wait for it to be taken, then advance the model
    task automatic send_bit(input logic b, input bit typed, input run_t typed_run);
        bit got;
        run_t r;
        while ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.bit_in <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        decode_bit(b, got, r);
        if (got)
            pending_runs.push_back(typed ? typed_run : r);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input int a, input int bl, input int lim);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_ALPHA;
        cfg_data <= CFG_DATA_W'(a);
        @(posedge clk);
        cfg_idx <= CFG_BUCKET;
        cfg_data <= CFG_DATA_W'(bl);
        @(posedge clk);
        cfg_idx <= CFG_LIMIT;
        cfg_data <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_we <= 1'b0;
        alpha_reg = a & 'h1FF;
        blen_reg = bl & 'h1FFFF;
        limit_reg = lim & 'h1FF;
    endtask

    always @(posedge clk) begin
        run_t got_run, want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got_run = '{out_ch.symbol, out_ch.run_count, out_ch.last};
            if (pending_runs.size() == 0) begin
                $display("%0t: unexpected run sym=%0d cnt=%0d last=%0d", $time,
                         got_run.symbol, got_run.run_count, got_run.last);
                errors++;
            end
            else begin
                want = pending_runs.pop_front();
                if (got_run !== want) begin
                    $display("%0t: expected sym=%0d cnt=%0d last=%0d, got sym=%0d cnt=%0d last=%0d",
                             $time, want.symbol, want.run_count, want.last,
                             got_run.symbol, got_run.run_count, got_run.last);
                    errors++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    // alpha 2, limit 1: full-length repeat, escape by rank, escape through
    // the third level with an out-of-range local index
    localparam logic [24:0] DIR_BITS = 25'b11_11_00_11111111_01_01_11_111_10;
    localparam int DIR_ROW_A = 11;
    localparam int DIR_ROW_B = 7;
    localparam int DIR_ROW_C = 0;

    initial begin
        int settings [6][4];
        int dens;
        run_t none;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ALPHA;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.bit_in = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        sent = 0;
        snd_idle = 12;
        rcv_idle = 70;
        none = '0;
        alpha_reg = 256;
        blen_reg = 1024;
        limit_reg = 16;
        lvl3 = 0;
        for (int i = 0; i < 256; i++) begin
            l2g[i] = 8'd0;
            lst[i] = 8'd0;
        end
        new_bucket();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first bucket runs under the reset map length: empty map, then one
        // repeat code that closes the one-symbol bucket
        write_regs(2, 1, 1);
        for (int i = 0; i < 266; i++) begin
            if (i == 265)
                send_bit(1'b0, 1'b1, '{8'd0, 9'd1, 1'b1});
            else
                send_bit(1'b0, 1'b0, none);
        end
        drain();

        write_regs(2, 300, 1);
        for (int i = 24; i >= 0; i--) begin
            if (i == DIR_ROW_A)
                send_bit(DIR_BITS[i], 1'b1, '{8'd0, 9'd256, 1'b0});
            else if (i == DIR_ROW_B)
                send_bit(DIR_BITS[i], 1'b1, '{8'd1, 9'd1, 1'b0});
            else if (i == DIR_ROW_C)
                send_bit(DIR_BITS[i], 1'b1, '{8'd0, 9'd1, 1'b0});
            else
                send_bit(DIR_BITS[i], 1'b0, none);
        end
        drain();

        // alpha, bucket length, list limit, map density in percent
        settings = '{'{16, 20, 16, 50}, '{256, 40, 256, 30}, '{12, 1, 4, 60},
                     '{0, 0, 0, 50}, '{511, 65536, 300, 90}, '{33, 7, 11, 70}};
        foreach (settings[p]) begin
            write_regs(settings[p][0], settings[p][1], settings[p][2]);
            dens = settings[p][3];
            // a new map length takes effect from the next bucket start on
            for (int n = 0; n < 120; n++) begin
                if (sent < 340) begin
                    snd_idle = 12;
                    rcv_idle = 70;
                end
                else if (sent < 680) begin
                    snd_idle = 70;
                    rcv_idle = 12;
                end
                else begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
                if (ph == PH_MAP)
                    send_bit($urandom_range(99) < dens, 1'b0, none);
                else
                    send_bit(1'($urandom_range(1)), 1'b0, none);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && pending_runs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
